/* hw/rtl/ipse_pkg.sv */
// Shared types and constants of the infrared pulse/space encoder.
package ipse_pkg;

    localparam int DUR_W    = 24;
    localparam int TOTAL_W  = 32;
    localparam int MAX_RUNS = 256;
    localparam int CNT_W    = $clog2(MAX_RUNS + 1);

    localparam int Q_DEPTH  = 4;
    localparam int Q_AW     = $clog2(Q_DEPTH);
    localparam int Q_CW     = $clog2(Q_DEPTH + 1);

    localparam int APB_AW   = 6;
    localparam int APB_DW   = 64;

    localparam logic [DUR_W-1:0]   DUR_MAX   = {DUR_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // input function codes
    typedef enum logic [2:0] {
        FUNC_SYMBOL = 3'd0,
        FUNC_PULSE  = 3'd1,
        FUNC_SPACE  = 3'd2,
        FUNC_SYNC   = 3'd3,
        FUNC_FLUSH  = 3'd4,
        FUNC_CLEAR  = 3'd5
    } t_func;

    // encoding modes; other codes act as pulse first
    localparam logic [2:0] MODE_PULSE_FIRST = 3'd0;
    localparam logic [2:0] MODE_SPACE_FIRST = 3'd1;
    localparam logic [2:0] MODE_BIPHASE     = 3'd2;
    localparam logic [2:0] MODE_RCMM        = 3'd3;
    localparam logic [2:0] MODE_XMP         = 3'd4;

    // register indexes (byte address = 8 * index)
    localparam logic [2:0] REG_MODE       = 3'd0;
    localparam logic [2:0] REG_ONE_PULSE  = 3'd1;
    localparam logic [2:0] REG_ONE_SPACE  = 3'd2;
    localparam logic [2:0] REG_ZERO_PULSE = 3'd3;
    localparam logic [2:0] REG_ZERO_SPACE = 3'd4;
    localparam logic [2:0] REG_TWO        = 3'd5;
    localparam logic [2:0] REG_THREE      = 3'd6;

    // operations handed from front to back
    typedef enum logic [2:0] {
        OP_PULSE = 3'd0,
        OP_SPACE = 3'd1,
        OP_SYNC  = 3'd2,
        OP_FLUSH = 3'd3,
        OP_CLEAR = 3'd4
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [DUR_W-1:0] dur;
    } t_op_item;

    typedef struct packed {
        logic [2:0]         mode;
        logic [DUR_W-1:0]   one_pulse;
        logic [DUR_W-1:0]   one_space;
        logic [DUR_W-1:0]   zero_pulse;
        logic [DUR_W-1:0]   zero_space;
        logic [2*DUR_W-1:0] two_timing;
        logic [2*DUR_W-1:0] three_timing;
    } t_cfg;

endpackage

/* hw/rtl/ipse_cfg.sv */
// Configuration register file with APB-style access.
module ipse_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ipse_pkg::APB_AW-1:0]  paddr,
    input  logic [ipse_pkg::APB_DW-1:0]  pwdata,
    output logic [ipse_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output ipse_pkg::t_cfg               o_cfg
);

    ipse_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [2:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ipse_pkg::APB_AW-1:3];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                ipse_pkg::REG_MODE:       r_cfg.mode         <= pwdata[2:0];
                ipse_pkg::REG_ONE_PULSE:  r_cfg.one_pulse    <= pwdata[ipse_pkg::DUR_W-1:0];
                ipse_pkg::REG_ONE_SPACE:  r_cfg.one_space    <= pwdata[ipse_pkg::DUR_W-1:0];
                ipse_pkg::REG_ZERO_PULSE: r_cfg.zero_pulse   <= pwdata[ipse_pkg::DUR_W-1:0];
                ipse_pkg::REG_ZERO_SPACE: r_cfg.zero_space   <= pwdata[ipse_pkg::DUR_W-1:0];
                ipse_pkg::REG_TWO:        r_cfg.two_timing   <= pwdata[2*ipse_pkg::DUR_W-1:0];
                ipse_pkg::REG_THREE:      r_cfg.three_timing <= pwdata[2*ipse_pkg::DUR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            ipse_pkg::REG_MODE:       prdata = ipse_pkg::APB_DW'(r_cfg.mode);
            ipse_pkg::REG_ONE_PULSE:  prdata = ipse_pkg::APB_DW'(r_cfg.one_pulse);
            ipse_pkg::REG_ONE_SPACE:  prdata = ipse_pkg::APB_DW'(r_cfg.one_space);
            ipse_pkg::REG_ZERO_PULSE: prdata = ipse_pkg::APB_DW'(r_cfg.zero_pulse);
            ipse_pkg::REG_ZERO_SPACE: prdata = ipse_pkg::APB_DW'(r_cfg.zero_space);
            ipse_pkg::REG_TWO:        prdata = ipse_pkg::APB_DW'(r_cfg.two_timing);
            ipse_pkg::REG_THREE:      prdata = ipse_pkg::APB_DW'(r_cfg.three_timing);
            default:                  prdata = '0;
        endcase
    end

endmodule

/* hw/rtl/ipse_front.sv */
// Front end: holds an input item, resolves symbol timings, issues pulse, space, sync, flush and clear operations.
module ipse_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ipse_pkg::t_cfg                i_cfg,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [31:0]                   i_s_tdata,
    input  logic [2:0]                    i_s_tuser,
    output logic                          o_push_valid,
    input  logic                          i_push_ready,
    output ipse_pkg::t_op_item            o_push_item
);

    localparam int DW = ipse_pkg::DUR_W;

    logic                 r_valid;
    logic                 r_phase;
    ipse_pkg::t_func      r_func;
    logic [3:0]           r_sym;
    logic                 r_dbl;
    logic [DW-1:0]        r_dur;

    logic                 accept;
    logic                 needs_push;
    logic                 is_sym;
    logic                 done;
    logic                 space_first;
    logic [DW-1:0]        sym_pulse;
    logic [DW-1:0]        sym_space;
    logic [DW+4:0]        xmp_space;
    logic [DW:0]          dbl_a;
    logic [DW:0]          dbl_b;

    function automatic logic [DW-1:0] sat_dbl(input logic [DW:0] v);
        return v[DW] ? ipse_pkg::DUR_MAX : v[DW-1:0];
    endfunction

    assign xmp_space = (DW+5)'(i_cfg.zero_space)
                     + (DW+5)'(r_sym) * (DW+5)'(i_cfg.one_space);

    // symbol timing selection
    always_comb begin
        space_first = 1'b0;
        sym_pulse   = i_cfg.zero_pulse;
        sym_space   = i_cfg.zero_space;
        dbl_a       = '0;
        dbl_b       = '0;
        if (i_cfg.mode == ipse_pkg::MODE_RCMM) begin
            case (r_sym[1:0])
                2'd0: begin
                    sym_pulse = i_cfg.zero_pulse;
                    sym_space = i_cfg.zero_space;
                end
                2'd1: begin
                    sym_pulse = i_cfg.one_pulse;
                    sym_space = i_cfg.one_space;
                end
                2'd2: begin
                    sym_pulse = i_cfg.two_timing[2*DW-1:DW];
                    sym_space = i_cfg.two_timing[DW-1:0];
                end
                default: begin
                    sym_pulse = i_cfg.three_timing[2*DW-1:DW];
                    sym_space = i_cfg.three_timing[DW-1:0];
                end
            endcase
        end else if (i_cfg.mode == ipse_pkg::MODE_XMP) begin
            sym_pulse = i_cfg.zero_pulse;
            sym_space = (xmp_space[DW+4:DW] != '0) ? ipse_pkg::DUR_MAX : xmp_space[DW-1:0];
        end else if (r_sym[0]) begin
            if (i_cfg.mode == ipse_pkg::MODE_BIPHASE) begin
                space_first = 1'b1;
                if (r_dbl) begin
                    dbl_a     = {i_cfg.one_pulse, 1'b0};
                    dbl_b     = {i_cfg.one_space, 1'b0};
                    sym_pulse = sat_dbl(dbl_a);
                    sym_space = sat_dbl(dbl_b);
                end else begin
                    sym_pulse = i_cfg.one_pulse;
                    sym_space = i_cfg.one_space;
                end
            end else begin
                space_first = (i_cfg.mode == ipse_pkg::MODE_SPACE_FIRST);
                sym_pulse   = i_cfg.one_pulse;
                sym_space   = i_cfg.one_space;
            end
        end else if (r_dbl) begin
            dbl_a     = {i_cfg.zero_pulse, 1'b0};
            dbl_b     = {i_cfg.zero_space, 1'b0};
            sym_pulse = sat_dbl(dbl_a);
            sym_space = sat_dbl(dbl_b);
        end else begin
            space_first = (i_cfg.mode == ipse_pkg::MODE_SPACE_FIRST);
        end
    end

    // operation decode
    always_comb begin
        needs_push       = 1'b1;
        o_push_item.op   = ipse_pkg::OP_SYNC;
        o_push_item.dur  = r_dur;
        unique case (r_func)
            ipse_pkg::FUNC_SYMBOL: begin
                if (space_first ^ r_phase) begin
                    o_push_item.op  = ipse_pkg::OP_SPACE;
                    o_push_item.dur = sym_space;
                end else begin
                    o_push_item.op  = ipse_pkg::OP_PULSE;
                    o_push_item.dur = sym_pulse;
                end
            end
            ipse_pkg::FUNC_PULSE: o_push_item.op = ipse_pkg::OP_PULSE;
            ipse_pkg::FUNC_SPACE: o_push_item.op = ipse_pkg::OP_SPACE;
            ipse_pkg::FUNC_SYNC:  o_push_item.op = ipse_pkg::OP_SYNC;
            ipse_pkg::FUNC_FLUSH: o_push_item.op = ipse_pkg::OP_FLUSH;
            ipse_pkg::FUNC_CLEAR: o_push_item.op = ipse_pkg::OP_CLEAR;
            default:              needs_push = 1'b0;
        endcase
    end

    assign is_sym       = (r_func == ipse_pkg::FUNC_SYMBOL);
    assign o_push_valid = r_valid && needs_push;
    assign done         = r_valid && (!needs_push || (i_push_ready && (!is_sym || r_phase)));
    assign o_s_tready   = !r_valid || done;
    assign accept       = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
            r_phase <= 1'b0;
        end else if (done) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else if (o_push_valid && i_push_ready) begin
            r_phase <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= ipse_pkg::t_func'(i_s_tuser);
            r_sym  <= i_s_tdata[3:0];
            r_dbl  <= i_s_tdata[4];
            r_dur  <= i_s_tdata[DW+4:5];
        end
    end

endmodule

/* hw/rtl/ipse_queue.sv */
// Short operation queue between the front and back ends.
module ipse_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push_valid,
    output logic                o_push_ready,
    input  ipse_pkg::t_op_item  i_push_item,
    output logic                o_pop_valid,
    input  logic                i_pop_ready,
    output ipse_pkg::t_op_item  o_pop_item
);

    ipse_pkg::t_op_item                r_mem [ipse_pkg::Q_DEPTH];
    logic [ipse_pkg::Q_AW-1:0]         r_wr_ptr;
    logic [ipse_pkg::Q_AW-1:0]         r_rd_ptr;
    logic [ipse_pkg::Q_CW-1:0]         r_count;
    logic                              push;
    logic                              pop;

    assign o_push_ready = (r_count != ipse_pkg::Q_CW'(ipse_pkg::Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

/* hw/rtl/ipse_back.sv */
// Back end: merges runs, keeps totals and drives the registered result stream.
module ipse_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_op_valid,
    output logic                o_op_ready,
    input  ipse_pkg::t_op_item  i_op_item,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [63:0]         o_m_tdata,
    output logic                o_m_tuser,
    output logic                o_m_tlast
);

    localparam int DW = ipse_pkg::DUR_W;
    localparam int TW = ipse_pkg::TOTAL_W;
    localparam int CW = ipse_pkg::CNT_W;

    logic [DW-1:0] r_pp, n_pp;
    logic [DW-1:0] r_ps, n_ps;
    logic [CW-1:0] r_count, n_count;
    logic [TW-1:0] r_total, n_total;
    logic          r_ovf_sticky, n_ovf_sticky;

    logic          r_out_valid;
    logic [DW-1:0] r_out_len;
    logic [TW-1:0] r_out_total;
    logic          r_out_ovf;
    logic          r_out_pulse;
    logic          r_out_last;

    logic          out_free;
    logic          step;
    logic          pop;
    logic          emit;
    logic [DW-1:0] emit_len;
    logic          emit_pulse;
    logic          emit_last;
    logic [DW:0]   merge_sum;
    logic [TW:0]   total_sum;
    logic [DW-1:0] pend;

    assign out_free   = !r_out_valid || i_m_tready;
    assign step       = i_op_valid && out_free;
    assign o_op_ready = step && pop;

    // one op per cycle while output is free; flush: pulse run before space run
    always_comb begin
        n_pp       = r_pp;
        n_ps       = r_ps;
        pop        = 1'b1;
        emit       = 1'b0;
        emit_len   = r_pp;
        emit_pulse = 1'b1;
        emit_last  = 1'b0;
        pend       = (i_op_item.op == ipse_pkg::OP_PULSE) ? r_pp : r_ps;
        merge_sum  = (DW+1)'(pend) + (DW+1)'(i_op_item.dur);
        unique case (i_op_item.op)
            ipse_pkg::OP_PULSE: begin
                if (r_pp != '0) begin
                    n_pp = merge_sum[DW] ? ipse_pkg::DUR_MAX : merge_sum[DW-1:0];
                end else begin
                    if (r_ps != '0) begin
                        emit       = 1'b1;
                        emit_len   = r_ps;
                        emit_pulse = 1'b0;
                    end
                    n_ps = '0;
                    n_pp = i_op_item.dur;
                end
            end
            ipse_pkg::OP_SPACE: begin
                // leading space with nothing emitted yet is dropped
                if (r_count != '0 || r_pp != '0) begin
                    if (r_ps != '0) begin
                        n_ps = merge_sum[DW] ? ipse_pkg::DUR_MAX : merge_sum[DW-1:0];
                    end else begin
                        if (r_pp != '0) begin
                            emit = 1'b1;
                        end
                        n_pp = '0;
                        n_ps = i_op_item.dur;
                    end
                end
            end
            ipse_pkg::OP_SYNC: begin
                if (r_pp != '0) begin
                    emit = 1'b1;
                end
                n_pp = '0;
            end
            ipse_pkg::OP_FLUSH: begin
                if (r_pp != '0) begin
                    emit      = 1'b1;
                    emit_last = (r_ps == '0);
                    n_pp      = '0;
                    pop       = (r_ps == '0);
                end else if (r_ps != '0) begin
                    emit       = 1'b1;
                    emit_len   = r_ps;
                    emit_pulse = 1'b0;
                    emit_last  = 1'b1;
                    n_ps       = '0;
                end
            end
            ipse_pkg::OP_CLEAR: begin
                n_pp = '0;
                n_ps = '0;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_count      = r_count;
        n_total      = r_total;
        n_ovf_sticky = r_ovf_sticky;
        total_sum    = (TW+1)'(r_total) + (TW+1)'(emit_len);
        if (i_op_item.op == ipse_pkg::OP_CLEAR) begin
            n_count      = '0;
            n_total      = '0;
            n_ovf_sticky = 1'b0;
        end else if (emit) begin
            if (r_count < CW'(ipse_pkg::MAX_RUNS)) begin
                n_total = total_sum[TW] ? ipse_pkg::TOTAL_MAX : total_sum[TW-1:0];
                n_count = r_count + 1'b1;
            end else begin
                n_ovf_sticky = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp         <= '0;
            r_ps         <= '0;
            r_count      <= '0;
            r_total      <= '0;
            r_ovf_sticky <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (step) begin
                r_pp         <= n_pp;
                r_ps         <= n_ps;
                r_count      <= n_count;
                r_total      <= n_total;
                r_ovf_sticky <= n_ovf_sticky;
            end
            if (step && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_out_len   <= emit_len;
            r_out_total <= n_total;
            r_out_ovf   <= n_ovf_sticky;
            r_out_pulse <= emit_pulse;
            r_out_last  <= emit_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0, r_out_ovf, r_out_total, r_out_len};
    assign o_m_tuser  = r_out_pulse;
    assign o_m_tlast  = r_out_last;

endmodule

/* hw/rtl/ir_pulse_space_encoder.sv */
// Infrared pulse/space transmit encoder, top level.
//
// Input stream: one item per symbol, raw pulse, raw space, sync, flush or clear
// (function code in tuser). Output stream: one item per completed run, with
// the run length, a saturating running total and the overflow flag in tdata,
// pulse/space in tuser, and tlast on the final run of a flush.
// Registers are written over the APB port at byte address 8 * index; pready
// is tied high. Write them only while the encoder is idle.
// A symbol item occupies the front end until both halves of its pulse/space
// pair are pushed, one operation each; every other item pushes at most one.
// The back end does one operation per cycle while its result register is
// free; a flush with both runs pending emits its pulse run, then its space run.
// A 4-entry operation queue sits between the ends, and the result register
// frees the back end whenever the receiver takes a result, so input keeps
// flowing until the queue fills while the receiver stalls.
// Reset clears the pending runs, counters, queue pointers and configuration registers to zero.
module ir_pulse_space_encoder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ipse_pkg::APB_AW-1:0]  paddr,
    input  logic [ipse_pkg::APB_DW-1:0]  pwdata,
    output logic [ipse_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [31:0]                  i_s_tdata,  // symbol[3:0], double_length[4], duration[28:5]
    input  logic [2:0]                   i_s_tuser,  // func[2:0]
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [63:0]                  o_m_tdata,  // run_length[23:0], total[55:24], overflow[56]
    output logic                         o_m_tuser,  // is_pulse
    output logic                         o_m_tlast
);

    ipse_pkg::t_cfg      cfg;
    logic                push_valid;
    logic                push_ready;
    ipse_pkg::t_op_item  push_item;
    logic                op_valid;
    logic                op_ready;
    ipse_pkg::t_op_item  op_item;

    ipse_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ipse_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_item  (push_item)
    );

    ipse_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (op_valid),
        .i_pop_ready  (op_ready),
        .o_pop_item   (op_item)
    );

    ipse_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (op_valid),
        .o_op_ready (op_ready),
        .i_op_item  (op_item),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
